@@ rtl/core/prdd_pkg.sv @@
// Package for the paired read descriptor decoder.
// Holds the token codes, error codes, field widths and the queue token type.
// No dependencies.
`default_nettype none

package prdd_pkg;

  // Default sizes of the storage.
  localparam int REF_DEPTH_DEF    = 65536;
  localparam int MAX_READ_LEN_DEF = 256;
  localparam int CHUNK_BASES_DEF  = 16;

  // Fixed field widths.
  localparam int BASE_W    = 3;
  localparam int LEN_W     = 9;
  localparam int DELTA_W   = 16;
  localparam int GAP_W     = 15;
  localparam int MMGAP_W   = 9;
  localparam int RUNPOS_W  = 17;
  localparam int OFF_W     = 10;
  localparam int PACK_W    = 48;
  localparam int COUNT_W   = 5;
  localparam int ERR_W     = 3;

  // Depth of the token queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  // Base codes.
  localparam logic [BASE_W-1:0] BASE_T = 3'd3;
  localparam logic [BASE_W-1:0] BASE_N = 3'd4;

  // Token commands.
  typedef enum logic [1:0] {
    CMD_REF = 2'd0,
    CMD_HDR = 2'd1,
    CMD_MM  = 2'd2,
    CMD_END = 2'd3
  } cmd_t;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
  localparam logic [ERR_W-1:0] ERR_MM_KIND  = 3'd1;
  localparam logic [ERR_W-1:0] ERR_MM_RANGE = 3'd2;
  localparam logic [ERR_W-1:0] ERR_REF_RANGE = 3'd3;
  localparam logic [ERR_W-1:0] ERR_FULL     = 3'd4;

  // A classified token as it waits in the queue.
  typedef struct packed {
    cmd_t                cmd;
    logic [BASE_W-1:0]   base;
    logic [DELTA_W-1:0]  pos_delta;
    logic [LEN_W-1:0]    len_first;
    logic [LEN_W-1:0]    len_second;
    logic                paired;
    logic [GAP_W-1:0]    gap;
    logic                rc_first;
    logic                rc_second;
    logic                has_mm;
    logic [MMGAP_W-1:0]  mm_gap;
    logic                kind_ok;
  } token_t;

  // Handshake between the queue and the back end.
  typedef struct packed {
    logic   valid;
    token_t tok;
  } queue_out_t;

  // Codes above N read as N.
  function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
    clamp_base = (b > BASE_N) ? BASE_N : b;
  endfunction

  // Complement of a base; N stays N.
  function automatic logic [BASE_W-1:0] comp_base(input logic [BASE_W-1:0] b);
    comp_base = (b < BASE_N) ? (BASE_T - b) : BASE_N;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/prdd_ifs.sv @@
// Channel interfaces of the paired read descriptor decoder.
// Depends on prdd_pkg for the field widths.
`default_nettype none

interface prdd_in_if;
  import prdd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [1:0]           cmd;
  logic [BASE_W-1:0]    base;
  logic [DELTA_W-1:0]   pos_delta;
  logic [LEN_W-1:0]     len_first;
  logic [LEN_W-1:0]     len_second;
  logic                 paired;
  logic [15:0]          pair_gap_raw;
  logic [1:0]           rcomp_bits;
  logic                 has_mismatches;
  logic [MMGAP_W-1:0]   mm_gap;
  logic [1:0]           mm_kind;

  modport source (output valid, cmd, base, pos_delta, len_first, len_second, paired,
                  pair_gap_raw, rcomp_bits, has_mismatches, mm_gap, mm_kind,
                  input ready);
  modport sink (input valid, cmd, base, pos_delta, len_first, len_second, paired,
                pair_gap_raw, rcomp_bits, has_mismatches, mm_gap, mm_kind,
                output ready);
endinterface

interface prdd_out_if;
  import prdd_pkg::*;
  logic               valid;
  logic               ready;
  logic [PACK_W-1:0]  bases_packed;
  logic [COUNT_W-1:0] base_count;
  logic               segment;
  logic               last_of_segment;
  logic               last;
  logic [ERR_W-1:0]   error;

  modport source (output valid, bases_packed, base_count, segment, last_of_segment,
                  last, error, input ready);
  modport sink (input valid, bases_packed, base_count, segment, last_of_segment,
                last, error, output ready);
endinterface

`default_nettype wire

@@ rtl/core/prdd_front.sv @@
// Front end: accepts token beats, classifies them and queues them.
// Depends on prdd_pkg and prdd_in_if.
`default_nettype none

module prdd_front
  import prdd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  prdd_in_if.sink     in_ch,
  output queue_out_t  q_out,
  input  wire logic   q_pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  token_t             queue [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;
  token_t             tok_in;
  logic               push;
  logic               pop;

  // Classify the incoming beat.
  always_comb begin
    tok_in.cmd        = cmd_t'(in_ch.cmd);
    tok_in.base       = clamp_base(in_ch.base);
    tok_in.pos_delta  = in_ch.pos_delta;
    tok_in.len_first  = in_ch.len_first;
    tok_in.len_second = in_ch.len_second;
    tok_in.paired     = in_ch.paired;
    tok_in.gap        = in_ch.pair_gap_raw[15:1];
    tok_in.rc_first   = in_ch.paired ? in_ch.rcomp_bits[1] : in_ch.rcomp_bits[0];
    tok_in.rc_second  = in_ch.rcomp_bits[0];
    tok_in.has_mm     = in_ch.has_mismatches;
    tok_in.mm_gap     = in_ch.mm_gap;
    tok_in.kind_ok    = (in_ch.mm_kind == 2'd0);
  end

  assign in_ch.ready = (count != (PTR_W+1)'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = q_pop && (count != '0);
  assign q_out.valid = (count != '0);
  assign q_out.tok   = queue[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= tok_in;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/prdd_back.sv @@
// Back end: reference store, segment buffer, mismatch handling and chunk output.
// Depends on prdd_pkg and prdd_out_if.
`default_nettype none

module prdd_back
  import prdd_pkg::*;
#(
  parameter int REF_DEPTH    = REF_DEPTH_DEF,
  parameter int MAX_READ_LEN = MAX_READ_LEN_DEF,
  parameter int CHUNK_BASES  = CHUNK_BASES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  queue_out_t q_in,
  output logic       q_pop,
  prdd_out_if.source out_ch
);

  localparam int ADDR_W    = $clog2(REF_DEPTH);
  localparam int FILL_W    = ADDR_W + 1;
  localparam int SUM_W     = ((FILL_W > 19) ? FILL_W : 19) + 1;
  localparam int BUF_DEPTH = 2 * MAX_READ_LEN;
  localparam int BUF_W     = $clog2(BUF_DEPTH);
  localparam int LANE_W    = $clog2(CHUNK_BASES + 1);
  localparam int PACKF_W   = BASE_W * CHUNK_BASES;
  localparam logic [10:0]       MAX_LEN_L = 11'(MAX_READ_LEN);
  localparam logic [LEN_W-1:0]  CHUNK_L   = LEN_W'(CHUNK_BASES);
  localparam logic [BUF_W-1:0]  SEG2_BASE = BUF_W'(MAX_READ_LEN);
  localparam logic [FILL_W-1:0] FULL_L    = FILL_W'(REF_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_HDR, S_COPY, S_EMIT, S_CHUNK, S_RD, S_WAIT, S_OUT, S_ERR
  } state_t;

  state_t              state;
  token_t              tok;

  // Record and stream state.
  logic [FILL_W-1:0]   fill;
  logic [RUNPOS_W-1:0] run_pos;
  logic                pend_valid;
  logic [ERR_W-1:0]    rec_err;
  logic [OFF_W-1:0]    mm_offset;
  logic                mm_seg;
  logic [LEN_W-1:0]    hdr_lf;
  logic [LEN_W-1:0]    hdr_ls;
  logic                hdr_paired;
  logic                hdr_rc0;
  logic                hdr_rc1;
  logic                hdr_has_mm;
  logic [GAP_W-1:0]    hdr_gap;

  // Copy sequencer.
  logic [ADDR_W-1:0]   cp_addr;
  logic [ADDR_W-1:0]   cp_start2;
  logic [LEN_W-1:0]    cp_left;
  logic [LEN_W-1:0]    cp_idx;
  logic                cp_seg;
  logic                cp_wr_en;
  logic [BUF_W-1:0]    cp_wr_idx;

  // Emission sequencer.
  logic                em_seg;
  logic [LEN_W-1:0]    em_pos;
  logic [LEN_W-1:0]    em_j;
  logic [LANE_W-1:0]   em_k;
  logic [LANE_W-1:0]   em_ccnt;
  logic                rd_v;
  logic [LANE_W-1:0]   rd_lane;
  logic [PACKF_W-1:0]  packed_q;
  logic [ERR_W-1:0]    err_q;

  // Memories.
  logic [BASE_W-1:0]   ref_mem [REF_DEPTH];
  logic [BASE_W-1:0]   seg_mem [BUF_DEPTH];
  logic [BASE_W-1:0]   store_q;
  logic [BASE_W-1:0]   buf_q;

  // Output register.
  logic                out_valid;
  logic                out_free;
  logic                out_load;

  // Combinational helpers.
  logic                pop_now;
  logic                ref_we;
  logic [SUM_W-1:0]    start1;
  logic [SUM_W-1:0]    end1;
  logic [SUM_W-1:0]    start2;
  logic [SUM_W-1:0]    end2;
  logic                hdr_bad;
  logic [OFF_W:0]      mm_sum;
  logic [OFF_W-1:0]    mm_sat;
  logic                mm_spill;
  logic [OFF_W-1:0]    mm_off;
  logic                mm_seg_new;
  logic [ERR_W-1:0]    mm_err;
  logic                mm_act;
  logic                buf_we;
  logic [BUF_W-1:0]    buf_wa;
  logic [BASE_W-1:0]   buf_wd;
  logic [BUF_W-1:0]    buf_ra;
  logic [LEN_W-1:0]    em_len;
  logic [LEN_W-1:0]    em_rem;
  logic [LANE_W-1:0]   em_cnt;
  logic                em_rc;
  logic [LEN_W-1:0]    em_idx;
  logic                em_lseg;
  logic [BASE_W-1:0]   gath_base;

  assign tok      = q_in.tok;
  assign pop_now  = (state == S_IDLE) && q_in.valid;
  assign q_pop    = pop_now;
  assign out_free = !out_valid || out_ch.ready;
  assign out_load = ((state == S_OUT) || (state == S_ERR)) && out_free;
  assign ref_we   = pop_now && (tok.cmd == CMD_REF) && (fill < FULL_L);

  // Range checks of a new record.
  always_comb begin
    start1  = SUM_W'(run_pos);
    end1    = start1 + SUM_W'(hdr_lf);
    start2  = end1 + SUM_W'(hdr_gap);
    end2    = start2 + SUM_W'(hdr_ls);
    hdr_bad = ({2'b00, hdr_lf} > MAX_LEN_L) ||
              (hdr_paired && ({2'b00, hdr_ls} > MAX_LEN_L)) ||
              (end1 > SUM_W'(fill)) ||
              (hdr_paired && (end2 > SUM_W'(fill)));
  end

  // Mismatch offset update, spill into the second segment and checks.
  always_comb begin
    mm_sum     = {1'b0, mm_offset} + (OFF_W+1)'(tok.mm_gap);
    mm_sat     = mm_sum[OFF_W] ? '1 : mm_sum[OFF_W-1:0];
    mm_spill   = !mm_seg && (mm_sat >= OFF_W'(hdr_lf));
    mm_off     = mm_spill ? (mm_sat - OFF_W'(hdr_lf)) : mm_sat;
    mm_seg_new = mm_seg || mm_spill;
    if (mm_spill && !hdr_paired) begin
      mm_err = ERR_MM_RANGE;
    end else if (mm_seg_new && (mm_off >= OFF_W'(hdr_ls))) begin
      mm_err = ERR_MM_RANGE;
    end else if (!tok.kind_ok) begin
      mm_err = ERR_MM_KIND;
    end else begin
      mm_err = ERR_NONE;
    end
    mm_act = pop_now && (tok.cmd == CMD_MM) && pend_valid && (rec_err == ERR_NONE);
  end

  // Segment buffer write port: copy beats or substitutions.
  always_comb begin
    if (cp_wr_en) begin
      buf_we = 1'b1;
      buf_wa = cp_wr_idx;
      buf_wd = store_q;
    end else begin
      buf_we = mm_act && (mm_err == ERR_NONE);
      buf_wa = mm_seg_new ? (SEG2_BASE + BUF_W'(mm_off)) : BUF_W'(mm_off);
      buf_wd = tok.base;
    end
  end

  // Chunk sizing and read address, reversed when the segment is complemented.
  always_comb begin
    em_len    = em_seg ? hdr_ls : hdr_lf;
    em_rc     = em_seg ? hdr_rc1 : hdr_rc0;
    em_rem    = em_len - em_pos;
    em_cnt    = (em_rem > CHUNK_L) ? LANE_W'(CHUNK_BASES) : LANE_W'(em_rem);
    em_idx    = em_rc ? (em_len - 1'b1 - em_j) : em_j;
    buf_ra    = em_seg ? (SEG2_BASE + BUF_W'(em_idx)) : BUF_W'(em_idx);
    em_lseg   = ((em_pos + LEN_W'(em_ccnt)) >= em_len);
    gath_base = em_rc ? comp_base(buf_q) : buf_q;
  end

  // Reference store.
  always_ff @(posedge clk) begin
    if (ref_we) begin
      ref_mem[fill[ADDR_W-1:0]] <= tok.base;
    end
    store_q <= ref_mem[cp_addr];
  end

  // Segment buffer.
  always_ff @(posedge clk) begin
    if (buf_we) begin
      seg_mem[buf_wa] <= buf_wd;
    end
    buf_q <= seg_mem[buf_ra];
  end

  // Sequencer state and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill       <= '0;
      run_pos    <= '0;
      pend_valid <= 1'b0;
      rec_err    <= ERR_NONE;
      mm_offset  <= '0;
      mm_seg     <= 1'b0;
      cp_wr_en   <= 1'b0;
      rd_v       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      cp_wr_en <= (state == S_COPY) && (cp_left != '0);
      rd_v     <= (state == S_RD);
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      // Gather the bases that arrive from the segment buffer.
      if (rd_v) begin
        packed_q[BASE_W*rd_lane +: BASE_W] <= gath_base;
      end
      unique case (state)
        S_IDLE: begin
          if (q_in.valid) begin
            unique case (tok.cmd)
              CMD_REF: begin
                if (fill < FULL_L) begin
                  fill <= fill + 1'b1;
                end else begin
                  err_q <= ERR_FULL;
                  state <= S_ERR;
                end
              end
              CMD_HDR: begin
                run_pos    <= run_pos + RUNPOS_W'(tok.pos_delta);
                pend_valid <= 1'b0;
                hdr_lf     <= tok.len_first;
                hdr_ls     <= tok.len_second;
                hdr_paired <= tok.paired;
                hdr_rc0    <= tok.rc_first;
                hdr_rc1    <= tok.rc_second;
                hdr_has_mm <= tok.has_mm;
                hdr_gap    <= tok.gap;
                mm_offset  <= '0;
                mm_seg     <= 1'b0;
                state      <= S_HDR;
              end
              CMD_MM: begin
                if (mm_act) begin
                  mm_offset <= mm_off;
                  mm_seg    <= mm_seg_new;
                  rec_err   <= mm_err;
                end
              end
              CMD_END: begin
                if (pend_valid) begin
                  pend_valid <= 1'b0;
                  state      <= S_EMIT;
                end
              end
              default: ;
            endcase
          end
        end
        S_HDR: begin
          // Check ranges; if they hold, start copying the first segment.
          cp_addr   <= ADDR_W'(start1);
          cp_start2 <= ADDR_W'(start2);
          cp_left   <= hdr_lf;
          cp_idx    <= '0;
          cp_seg    <= 1'b0;
          if (hdr_bad) begin
            rec_err <= ERR_REF_RANGE;
            if (hdr_has_mm) begin
              pend_valid <= 1'b1;
              state      <= S_IDLE;
            end else begin
              state <= S_EMIT;
            end
          end else begin
            rec_err <= ERR_NONE;
            state   <= S_COPY;
          end
        end
        S_COPY: begin
          if (cp_left != '0) begin
            cp_wr_idx <= cp_seg ? (SEG2_BASE + BUF_W'(cp_idx)) : BUF_W'(cp_idx);
            cp_addr   <= cp_addr + 1'b1;
            cp_idx    <= cp_idx + 1'b1;
            cp_left   <= cp_left - 1'b1;
          end else if (!cp_seg && hdr_paired) begin
            cp_seg  <= 1'b1;
            cp_addr <= cp_start2;
            cp_left <= hdr_ls;
            cp_idx  <= '0;
          end else if (hdr_has_mm) begin
            pend_valid <= 1'b1;
            state      <= S_IDLE;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          em_seg <= 1'b0;
          em_pos <= '0;
          if (rec_err != ERR_NONE) begin
            err_q <= rec_err;
            state <= S_ERR;
          end else begin
            state <= S_CHUNK;
          end
        end
        S_CHUNK: begin
          em_ccnt  <= em_cnt;
          em_j     <= em_pos;
          em_k     <= '0;
          packed_q <= '0;
          state    <= (em_cnt == '0) ? S_OUT : S_RD;
        end
        S_RD: begin
          // One buffer read per cycle; the read data is registered and lands in the next cycle.
          rd_lane <= em_k;
          em_j    <= em_j + 1'b1;
          em_k    <= em_k + 1'b1;
          if (em_k == em_ccnt - 1'b1) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_ch.bases_packed    <= PACK_W'(packed_q);
            out_ch.base_count      <= COUNT_W'(em_ccnt);
            out_ch.segment         <= em_seg;
            out_ch.last_of_segment <= em_lseg;
            out_ch.last            <= em_lseg && (em_seg || !hdr_paired);
            out_ch.error           <= ERR_NONE;
            if (!em_lseg) begin
              em_pos <= em_pos + LEN_W'(em_ccnt);
              state  <= S_CHUNK;
            end else if (!em_seg && hdr_paired) begin
              em_seg <= 1'b1;
              em_pos <= '0;
              state  <= S_CHUNK;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_ERR: begin
          if (out_free) begin
            out_ch.bases_packed    <= '0;
            out_ch.base_count      <= '0;
            out_ch.segment         <= 1'b0;
            out_ch.last_of_segment <= 1'b1;
            out_ch.last            <= 1'b1;
            out_ch.error           <= err_q;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid = out_valid;

endmodule

`default_nettype wire

@@ rtl/core/paired_read_descriptor_decoder.sv @@
// Paired read descriptor decoder, top level.
// Depends on prdd_pkg, prdd_ifs, prdd_front and prdd_back.
//
// Token beats enter a four-entry queue and are carried out one at a time by
// the back end. Reference bases, mismatches and end tokens are handled as they
// leave the queue. A read header checks its ranges and, if they hold, copies
// its segments, the first and, when paired, the second, from the reference
// store, which has one read port. Emission then reads each chunk base by base
// through the single read port of the segment buffer; a record in error gives
// its one result through the error state once emission starts, and a
// store-full base gives its result through the error state after it leaves the
// queue. Each result waits in an output register, so the queue keeps taking
// beats while it waits. No clearing pass is needed after reset.
`default_nettype none

module paired_read_descriptor_decoder
  import prdd_pkg::*;
#(
  parameter int REF_DEPTH    = REF_DEPTH_DEF,
  parameter int MAX_READ_LEN = MAX_READ_LEN_DEF,
  parameter int CHUNK_BASES  = CHUNK_BASES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  prdd_in_if.sink    in_ch,
  prdd_out_if.source out_ch
);

  queue_out_t q_out;
  logic       q_pop;

  // Front: accept and queue tokens.
  prdd_front u_front (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .q_out (q_out),
    .q_pop (q_pop)
  );

  // Back: stores, mismatch handling and chunk output.
  prdd_back #(
    .REF_DEPTH    (REF_DEPTH),
    .MAX_READ_LEN (MAX_READ_LEN),
    .CHUNK_BASES  (CHUNK_BASES)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_in   (q_out),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire
